/* sv/tcpiq_pkg.sv */
// shared types and constants for the two-class priority insert queue
`timescale 1ns / 1ps
package tcpiq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_W       = 16;

  localparam logic [VAL_W-1:0] THRESHOLD_RESET = 16'd65;

  localparam logic [1:0] MODE_APPEND   = 2'd0;
  localparam logic [1:0] MODE_PRIORITY = 2'd1;
  localparam logic [1:0] MODE_DUMP     = 2'd2;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [1:0] STATUS_ENTRY    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    cell_op_t                op;
    logic                    use_run;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] threshold;
  } cell_ctl_t;

endpackage

/* sv/tcpiq_cell.sv */
// one queue slot: holds an entry, classifies it and shifts with its neighbors
`timescale 1ns / 1ps
module tcpiq_cell (
  input  logic                              clk,
  input  tcpiq_pkg::cell_ctl_t              ctl,
  input  logic [tcpiq_pkg::IDX_W-1:0]       idx,
  input  logic                              run_in,
  input  logic signed [tcpiq_pkg::VAL_W-1:0] prev_value,
  input  logic signed [tcpiq_pkg::VAL_W-1:0] next_value,
  input  logic signed [tcpiq_pkg::VAL_W-1:0] head_value,
  output logic signed [tcpiq_pkg::VAL_W-1:0] value,
  output logic                              pri,
  output logic                              tail_np
);
  import tcpiq_pkg::*;

  logic [CNT_W-1:0] idx_ext;
  logic             is_tail;
  logic             at_count;

  assign idx_ext  = CNT_W'(idx);
  assign pri      = value >= ctl.threshold;
  assign is_tail  = (ctl.count != '0) && (idx_ext == ctl.count - CNT_W'(1));
  assign at_count = idx_ext == ctl.count;
  assign tail_np  = is_tail && !pri;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INSERT: begin
        if (ctl.use_run) begin
          // entries after the leading priority run move one step back
          if (!run_in) begin
            value <= prev_value;
          end else if (!pri) begin
            value <= ctl.value;
          end
        end else if (at_count) begin
          value <= ctl.value;
        end
      end
      OP_ROTATE: begin
        if (is_tail) begin
          value <= head_value;
        end else begin
          value <= next_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/two_class_priority_insert_queue.sv */
// top level: control, output register and the row of queue cells
// Two-class priority insert queue.
// Input channel s_*: s_tuser carries the mode (0 append, 1 priority insert,
// 2 dump), s_tdata the signed 16-bit value. Output channel m_*: m_tuser
// carries the status, m_tdata the dumped entry (zero otherwise), m_tlast
// marks the final result of one input transaction.
// cfg_wr_en / cfg_wr_data write the signed priority threshold (reset 65).
// An insert is handled without iteration: every cell compares its entry with
// the threshold in parallel and the row shifts at most once, so inserts run at
// one per cycle while the output is free; the result is registered on the
// output register in the cycle after accept. A dump rotates the row toward the
// head, one entry per cycle while the output is free, once per stored entry,
// and the row is back in order after the last one; the input is not ready
// during a dump. A dump of an empty queue gives one result.
// An insert into a full queue gives a dropped status and leaves the queue.
// Reset empties the queue, restores the threshold and holds the input not ready.
// When the receiver stalls, the held result stays on the output register
// and neither new inputs nor dump steps proceed until it is taken.
`timescale 1ns / 1ps
module two_class_priority_insert_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // item_value
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // entry_value
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast,   // last_result
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tcpiq_pkg::*;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        dump_idx, dump_idx_next;
  logic signed [VAL_W-1:0] threshold;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] cell_value [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  pri;
  logic [QUEUE_DEPTH-1:0]  tail_np;
  logic [QUEUE_DEPTH-1:0]  run;

  logic                    out_free;
  logic                    accept;
  logic                    item_pri;
  logic                    out_load;
  logic [1:0]              out_status;
  logic [VAL_W-1:0]        out_value;
  logic                    out_last;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign item_pri = $signed(s_tdata) >= threshold;

  assign run[0] = 1'b1;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i < QUEUE_DEPTH - 1) begin : g_run
        assign run[i+1] = run[i] && pri[i];
      end
      tcpiq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .idx        (IDX_W'(i)),
        .run_in     (run[i]),
        .prev_value (cell_value[(i == 0) ? 0 : i - 1]),
        .next_value (cell_value[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
        .head_value (cell_value[0]),
        .value      (cell_value[i]),
        .pri        (pri[i]),
        .tail_np    (tail_np[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      threshold <= THRESHOLD_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= out_value;
      m_tlast <= out_last;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    ctl.op        = OP_NONE;
    ctl.use_run   = 1'b0;
    ctl.count     = count;
    ctl.value     = $signed(s_tdata);
    ctl.threshold = threshold;
    out_load      = 1'b0;
    out_status    = STATUS_ACCEPTED;
    out_value     = '0;
    out_last      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (s_tuser == MODE_APPEND || s_tuser == MODE_PRIORITY) begin
            out_load = 1'b1;
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              out_status = STATUS_DROPPED;
            end else begin
              ctl.op      = OP_INSERT;
              ctl.use_run = (s_tuser == MODE_PRIORITY) && (count != '0) && item_pri
                            && (|tail_np);
              count_next  = count + CNT_W'(1);
            end
          end else if (s_tuser == MODE_DUMP) begin
            if (count == '0) begin
              out_load   = 1'b1;
              out_status = STATUS_EMPTY;
            end else begin
              state_next    = ST_DUMP;
              dump_idx_next = '0;
            end
          end else begin
            // unused mode: no result and no change
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_status    = STATUS_ENTRY;
          out_value     = cell_value[0];
          out_last      = dump_idx == count - CNT_W'(1);
          ctl.op        = OP_ROTATE;
          dump_idx_next = dump_idx + CNT_W'(1);
          if (out_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> !s_tready)
    else $error("input ready during dump");

  a_dump_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> (dump_idx < count))
    else $error("dump index past tail");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == MODE_APPEND || s_tuser == MODE_PRIORITY)
     && count != CNT_W'(QUEUE_DEPTH))
    |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not count the new entry");

  a_count_stable_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> $stable(count))
    else $error("entry count changed during dump");

endmodule
